@@ hw/rtl/button_scan_release_debouncer_defines.svh @@
// Assertion helpers for the RTL, used by the job queue.
`ifndef BUTTON_SCAN_RELEASE_DEBOUNCER_DEFINES_SVH
`define BUTTON_SCAN_RELEASE_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BSRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bsrd_pkg.sv @@
package bsrd_pkg;

  localparam int FRAME_BYTES   = 16;
  localparam int WARMUP_FRAMES = 3;
  localparam int ROWS          = 16;
  localparam int QDEPTH        = 4;
  localparam int QAW           = 2;

  localparam logic [6:0] PRESENCE_ID = 7'h77;

  localparam logic [1:0] CMD_SCAN    = 2'd0;
  localparam logic [1:0] CMD_POLL    = 2'd1;
  localparam logic [1:0] CMD_EMULATE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] byte_index;
    logic [7:0] scan_byte;
    logic       end_of_frame;
    logic [6:0] button_id;
    logic       emulate_press;
    logic       panel_online;
  } in_word_t;

  typedef struct packed {
    logic [6:0] event_id;
    logic       pressed;
    logic       last;
  } out_word_t;

  // One queued job: up to eight events sharing the upper id bits.
  // Bit j of mask stands for id {id_hi, ~j}.
  typedef struct packed {
    logic [3:0] id_hi;
    logic [7:0] mask;
    logic [7:0] press;
  } job_t;

  typedef logic [QAW:0] qcnt_t;

endpackage

@@ hw/rtl/bsrd_front.sv @@
module bsrd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bsrd_pkg::in_word_t item,
  input  bsrd_pkg::qcnt_t    q_count,
  output logic               full,
  output logic               job_push,
  output bsrd_pkg::job_t     job
);
  import bsrd_pkg::*;

  logic [1:0] cur;
  logic [1:0] warm;
  logic [3:0][7:0] mem [ROWS];
  logic [3:0] vld [ROWS];

  logic       accept;
  logic       is_scan;
  logic       scan_in_range;
  logic [3:0] rd_row;

  logic       s1_valid;
  in_word_t   s1;
  logic [1:0] s1_cur;
  logic       s1_live;
  logic [3:0][7:0] rd;
  logic [3:0] rv;

  logic [3:0][7:0] hb;
  logic [7:0] head, tail, mid1, mid2, changed, sel;
  logic [2:0] bitpos;
  logic       poll_in_range;
  logic       poll_val;

  // s1 reserves a queue slot, so a word in flight always has room.
  assign full     = (q_count + qcnt_t'(s1_valid)) >= qcnt_t'(QDEPTH);
  assign accept   = push & ~full;
  assign is_scan  = item.command == CMD_SCAN;
  assign scan_in_range = {1'b0, item.byte_index} < 5'(FRAME_BYTES);
  assign rd_row   = is_scan ? item.byte_index : item.button_id[6:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= 2'd0;
      warm     <= 2'(WARMUP_FRAMES);
      s1_valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        vld[r] <= 4'd0;
      end
    end else begin
      s1_valid <= accept;
      if (accept && is_scan) begin
        if (scan_in_range) begin
          vld[item.byte_index][cur] <= 1'b1;
        end
        if (item.end_of_frame) begin
          cur <= cur + 2'd1;
          if (warm != 2'd0) begin
            warm <= warm - 2'd1;
          end
        end
      end
    end
  end

  // Row holds all four frames of one byte; old frames read before the write lands.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd      <= mem[rd_row];
      rv      <= vld[rd_row];
      s1      <= item;
      s1_cur  <= cur;
      s1_live <= (warm == 2'd0) && item.panel_online && scan_in_range;
      if (is_scan && scan_in_range) begin
        mem[item.byte_index][cur] <= item.scan_byte;
      end
    end
  end

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      hb[f] = rd[f] & {8{rv[f]}};
    end
    head    = s1.scan_byte;
    tail    = hb[2'(s1_cur + 2'd1)];
    mid2    = hb[2'(s1_cur + 2'd2)];
    mid1    = hb[2'(s1_cur + 2'd3)];
    changed = (head ^ tail) & mid1 & mid2 & {8{s1_live}};
    if (s1.byte_index == PRESENCE_ID[6:3]) begin
      changed = changed & ~(8'd1 << ~PRESENCE_ID[2:0]);
    end
    bitpos        = ~s1.button_id[2:0];
    sel           = 8'd1 << bitpos;
    poll_in_range = {1'b0, s1.button_id[6:3]} < 5'(FRAME_BYTES);
    if (s1.button_id == PRESENCE_ID) begin
      poll_val = s1.panel_online;
    end else if (poll_in_range) begin
      poll_val = ~hb[2'(s1_cur + 2'd3)][bitpos];
    end else begin
      poll_val = 1'b0;
    end

    unique case (s1.command)
      CMD_SCAN: begin
        job.id_hi = s1.byte_index;
        job.mask  = changed;
        job.press = ~head;
      end
      CMD_POLL: begin
        job.id_hi = s1.button_id[6:3];
        job.mask  = sel;
        job.press = {8{poll_val}};
      end
      CMD_EMULATE: begin
        job.id_hi = s1.button_id[6:3];
        job.mask  = (s1.button_id == PRESENCE_ID) ? 8'd0 : sel;
        job.press = {8{s1.emulate_press}};
      end
      default: begin
        job.id_hi = s1.button_id[6:3];
        job.mask  = 8'd0;
        job.press = 8'd0;
      end
    endcase
  end

  assign job_push = s1_valid && (job.mask != 8'd0);

endmodule

@@ hw/rtl/bsrd_queue.sv @@
`include "button_scan_release_debouncer_defines.svh"

module bsrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  bsrd_pkg::job_t  wr_job,
  input  logic            rd,
  output logic            nonempty,
  output bsrd_pkg::job_t  head,
  output bsrd_pkg::qcnt_t count
);
  import bsrd_pkg::*;

  job_t           slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;

  assign nonempty = count != qcnt_t'(0);
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QAW'(1);
      end
      if (rd) begin
        rptr <= rptr + QAW'(1);
      end
      unique case ({wr, rd})
        2'b10:   count <= count + qcnt_t'(1);
        2'b01:   count <= count - qcnt_t'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  `BSRD_ASSERT_NOW(a_no_overflow, wr, count < qcnt_t'(QDEPTH), "job queue overflow")
  `BSRD_ASSERT_NOW(a_no_underflow, rd, count != qcnt_t'(0), "job queue underflow")
  `BSRD_ASSERT_NEXT(a_count_moves, wr && !rd, count != qcnt_t'(0), "count lost a push")

endmodule

@@ hw/rtl/bsrd_back.sv @@
module bsrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  bsrd_pkg::job_t      q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output bsrd_pkg::out_word_t result
);
  import bsrd_pkg::*;

  logic       busy;
  job_t       cj;
  logic       out_valid;
  logic       out_ready;
  logic       step;
  logic       is_last;
  logic [2:0] j;
  logic [7:0] sel;

  // Lowest set bit first: highest id of the byte goes out first.
  always_comb begin
    j = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cj.mask[i]) begin
        j = 3'(i);
      end
    end
  end

  assign sel       = 8'd1 << j;
  assign is_last   = (cj.mask & ~sel) == 8'd0;
  assign out_ready = ~out_valid | pop;
  assign step      = busy & out_ready;
  assign q_pop     = q_valid & (~busy | (step & is_last));
  assign empty     = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (step && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cj <= q_head;
    end else if (step) begin
      cj.mask <= cj.mask & ~sel;
    end
    if (step) begin
      result.event_id <= {cj.id_hi, ~j};
      result.pressed  <= cj.press[j];
      result.last     <= is_last;
    end
  end

endmodule

@@ hw/rtl/button_scan_release_debouncer.sv @@
// channel  | handshake          | word
// ---------+--------------------+------------------------------------------
// item     | push / full        | in_word_t: command, byte, id, flags
// result   | pop / empty        | out_word_t: event_id, pressed, last
//
// One item is taken per cycle while the job queue has room; each item leaves
// at most one job in a four-entry queue between front and back.
// The event sequencer emits one word per cycle while pop keeps up, so a scan
// byte yields one word per event (0 to 8), passing s1, the queue and cj.
// Reset clears the history valid bits at once; no clearing pass is needed.
// A stalled pop backs up the sequencer, then the queue, then raises full.
module button_scan_release_debouncer (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bsrd_pkg::in_word_t  item,
  output logic                empty,
  input  logic                pop,
  output bsrd_pkg::out_word_t result
);
  import bsrd_pkg::*;

  logic  job_push;
  job_t  job;
  logic  q_valid;
  logic  q_pop;
  job_t  q_head;
  qcnt_t q_count;

  bsrd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .q_count  (q_count),
    .full     (full),
    .job_push (job_push),
    .job      (job)
  );

  bsrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .wr_job   (job),
    .rd       (q_pop),
    .nonempty (q_valid),
    .head     (q_head),
    .count    (q_count)
  );

  bsrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

@@ test/bsrd_event_checker.sv @@
module bsrd_event_checker
  import bsrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_word_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_word_t result,
  output int        mismatches,
  output int        outstanding
);

  // four frames of 16 line bytes, indexed {frame, byte}
  logic [7:0] lines [64];
  logic [1:0] fill_ptr;
  logic [1:0] warmup_left;
  out_word_t  pending_events [$];
  out_word_t  due;
  int         bad;

  task automatic predict_events(input in_word_t w);
    logic [1:0] cur;
    logic [1:0] prev;
    logic [7:0] head;
    logic [7:0] mid1;
    logic [7:0] mid2;
    logic [7:0] tail;
    logic [7:0] moved;
    logic [7:0] row;
    logic [6:0] id;
    logic       level_low;
    out_word_t  evs [8];
    out_word_t  ev;
    int         n;
    n = 0;
    case (w.command)
      CMD_SCAN: begin
        cur = fill_ptr;
        if (int'(w.byte_index) < FRAME_BYTES) begin
          lines[{cur, w.byte_index}] = w.scan_byte;
          if (warmup_left == 2'd0 && w.panel_online) begin
            head = w.scan_byte;
            prev = cur + 2'd3;
            mid1 = lines[{prev, w.byte_index}];
            prev = cur + 2'd2;
            mid2 = lines[{prev, w.byte_index}];
            prev = cur + 2'd1;
            tail = lines[{prev, w.byte_index}];
            // 1110 -> press, 0111 -> release (oldest first)
            moved = (head ^ tail) & mid1 & mid2;
            for (int j = 0; j < 8; j++) begin
              id = {w.byte_index, 3'(7 - j)};
              if (moved[j] && id != PRESENCE_ID) begin
                evs[n] = '{event_id: id, pressed: !head[j], last: 1'b0};
                n++;
              end
            end
          end
        end
        if (w.end_of_frame) begin
          fill_ptr = cur + 2'd1;
          if (warmup_left != 2'd0) warmup_left = warmup_left - 2'd1;
        end
      end
      CMD_POLL: begin
        if (w.button_id == PRESENCE_ID) begin
          level_low = w.panel_online;
        end else if (int'(w.button_id[6:3]) < FRAME_BYTES) begin
          // newest completed frame
          prev = fill_ptr + 2'd3;
          row = lines[{prev, w.button_id[6:3]}];
          level_low = !row[7 - w.button_id[2:0]];
        end else begin
          level_low = 1'b0;
        end
        evs[0] = '{event_id: w.button_id, pressed: level_low, last: 1'b0};
        n = 1;
      end
      CMD_EMULATE: begin
        if (w.button_id != PRESENCE_ID) begin
          evs[0] = '{event_id: w.button_id, pressed: w.emulate_press, last: 1'b0};
          n = 1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      ev = evs[i];
      ev.last = (i == n - 1);
      pending_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (lines[i]) lines[i] = '0;
      fill_ptr = '0;
      warmup_left = 2'(WARMUP_FRAMES);
      pending_events.delete();
    end else begin
      // a word popped at this edge cannot come from an item pushed at it
      if (pop && !empty) begin
        if (pending_events.size() == 0) begin
          $error("unexpected word: event_id %0d pressed %0d last %0d",
                 result.event_id, result.pressed, result.last);
          bad++;
        end else begin
          due = pending_events.pop_front();
          if (result.event_id !== due.event_id) begin
            $error("event_id: expected %0d, actual %0d", due.event_id, result.event_id);
            bad++;
          end
          if (result.pressed !== due.pressed) begin
            $error("pressed: expected %0d, actual %0d", due.pressed, result.pressed);
            bad++;
          end
          if (result.last !== due.last) begin
            $error("last: expected %0d, actual %0d", due.last, result.last);
            bad++;
          end
        end
      end
      if (push && !full) predict_events(item);
    end
    outstanding <= pending_events.size();
    mismatches <= bad;
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import bsrd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS       = 300;
  localparam int CALM_ITEMS  = 60;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_TAIL  = 20;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  item;
  logic      empty;
  logic      pop;
  out_word_t result;
  int        mismatches;
  int        outstanding;
  int        cycle_count;
  int        sent;
  logic      calm;
  logic      hold_req;
  bit [7:0]  levels [16];

  button_scan_release_debouncer u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  bsrd_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random pop stalls, plus one long hold on request
  initial begin
    int stall;
    bit hold_served;
    stall = 0;
    hold_served = 1'b0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [3:0] idx,
                                         input logic [7:0] lv, input logic eof,
                                         input logic [6:0] id, input logic prs,
                                         input logic online);
    in_word_t w;
    w.command = cmd;
    w.byte_index = idx;
    w.scan_byte = lv;
    w.end_of_frame = eof;
    w.button_id = id;
    w.emulate_press = prs;
    w.panel_online = online;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    return make_word(2'($urandom_range(0, 3)), 4'($urandom), 8'($urandom), 1'($urandom),
                     7'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    int n;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // polls before any frame, presence polls, emulation corners, unused command
    send_word(make_word(CMD_POLL, 4'h0, 8'h00, 1'b0, PRESENCE_ID, 1'b0, 1'b0));
    send_word(make_word(CMD_POLL, 4'h0, 8'h00, 1'b0, PRESENCE_ID, 1'b0, 1'b1));
    send_word(make_word(CMD_POLL, 4'h0, 8'h00, 1'b0, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_POLL, 4'hF, 8'hFF, 1'b0, 7'h7F, 1'b1, 1'b1));
    send_word(make_word(CMD_EMULATE, 4'h0, 8'h00, 1'b0, PRESENCE_ID, 1'b1, 1'b1));
    send_word(make_word(CMD_EMULATE, 4'h0, 8'h00, 1'b0, 7'h7F, 1'b1, 1'b1));
    send_word(make_word(CMD_EMULATE, 4'h0, 8'h00, 1'b0, 7'h00, 1'b0, 1'b0));
    send_word(make_word(CMD_UNUSED, 4'hF, 8'hFF, 1'b1, 7'h7F, 1'b1, 1'b1));
    // warmup: three short frames only fill history
    send_word(make_word(CMD_SCAN, 4'h0, 8'h00, 1'b0, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hF, 8'h00, 1'b0, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_POLL, 4'h0, 8'h00, 1'b0, 7'h70, 1'b0, 1'b1));
    // byte 14 goes low: press on every line but the presence id
    send_word(make_word(CMD_SCAN, 4'hE, 8'h00, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_POLL, 4'h0, 8'h00, 1'b0, 7'h70, 1'b0, 1'b1));
    // low twice, then high three frames: release on the third
    send_word(make_word(CMD_SCAN, 4'hE, 8'h00, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hE, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b1));
    send_word(make_word(CMD_SCAN, 4'hF, 8'hFF, 1'b1, 7'h00, 1'b0, 1'b0));

    // hold the result side off while polls keep coming, so full rises
    hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      w = rand_word();
      w.command = CMD_POLL;
      send_word(w);
    end
    wait_drained();

    foreach (levels[b]) levels[b] = 8'hFF;
    while (sent < ITEMS) begin
      if (sent >= ITEMS - CALM_ITEMS) calm <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // well-formed frame: sparse line changes, now and then a full reshuffle
          for (int b = 0; b < 16; b++) begin
            if ($urandom_range(0, 9) == 0) begin
              w = rand_word();
              w.command = CMD_POLL;
              send_word(w);
            end
            case ($urandom_range(0, 9))
              0:             levels[b] = 8'($urandom);
              1, 2, 3, 4, 5: levels[b] = levels[b] ^ 8'($urandom & $urandom & $urandom);
              default: ;
            endcase
            w = rand_word();
            w.command = CMD_SCAN;
            w.byte_index = 4'(b);
            w.scan_byte = levels[b];
            w.end_of_frame = (b == 15);
            w.panel_online = ($urandom_range(0, 15) != 0);
            send_word(w);
          end
        end
        6: begin
          n = $urandom_range(1, 16);
          for (int i = 0; i < n; i++) begin
            w = rand_word();
            w.command = CMD_SCAN;
            w.end_of_frame = ($urandom_range(0, 3) == 0);
            send_word(w);
          end
        end
        7: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            w = rand_word();
            w.command = CMD_POLL;
            if ($urandom_range(0, 7) == 0) w.button_id = PRESENCE_ID;
            send_word(w);
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            w = rand_word();
            w.command = ($urandom_range(0, 9) == 0) ? CMD_UNUSED : CMD_EMULATE;
            if ($urandom_range(0, 7) == 0) w.button_id = PRESENCE_ID;
            send_word(w);
          end
        end
        default: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_word(rand_word());
          if (!calm && $urandom_range(0, 3) == 0) wait_drained();
        end
      endcase
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
